FILE: hw/rtl/jse_pkg.sv
// Shared types and constants for the JSON string escaper.
// Holds the command word passed from front to back. No dependencies.
`default_nettype none
package jse_pkg;

  localparam logic [7:0] QUOTE  = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] LF     = 8'h0A;
  localparam logic [7:0] TAB    = 8'h09;
  localparam logic [7:0] CHR_N  = 8'h6E;
  localparam logic [7:0] CHR_T  = 8'h74;
  localparam logic [7:0] CHR_U  = 8'h75;
  localparam logic [7:0] CHR_0  = 8'h30;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [20:0] CP_MIN3 = 21'h000800;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;
  localparam logic [20:0] CP_MIN4 = 21'h010000;
  localparam logic [20:0] CP_MAX  = 21'h10FFFF;

  // bytes of the replacement escape, one per index
  localparam logic [2:0] REP_LEN = 3'd6;

  // one command word: open quote, replacements, escaped body, replacements, close quote
  typedef struct packed {
    logic            open;
    logic [2:0]      rep1;
    logic [2:0]      body_len;
    logic [5:0][7:0] body;
    logic [1:0]      rep2;
    logic            close;
  } jse_cmd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) r = 8'h30 + {4'h0, v};
    else           r = 8'h57 + {4'h0, v};
    return r;
  endfunction

  function automatic logic [7:0] rep_char(input logic [2:0] k);
    logic [7:0] r;
    case (k)
      3'd0:    r = BSLASH;
      3'd1:    r = CHR_U;
      3'd2:    r = 8'h66;
      3'd3:    r = 8'h66;
      3'd4:    r = 8'h66;
      3'd5:    r = 8'h64;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/jse_front.sv
// Front end: accepts string bytes, tracks UTF-8 sequence state, builds command words.
// Depends on jse_pkg.
`default_nettype none
module jse_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_has_byte,
  input  wire logic              in_end_of_string,
  output jse_pkg::jse_cmd_t      cmd,
  output logic                   cmd_valid
);

  logic [7:0] held_bytes_r [3];
  logic [1:0] held_count_r, held_count_nxt;
  logic [2:0] seq_len_r, seq_len_nxt;
  logic       open_r, open_nxt;
  logic       wr_en;
  logic [1:0] wr_idx;
  logic       cont;
  logic [20:0] cp;
  logic       cp_ok;

  always_comb begin
    cont = (in_byte[7:6] == 2'b10);
    case (seq_len_r)
      3'd2:    cp = {10'd0, held_bytes_r[0][4:0], in_byte[5:0]};
      3'd3:    cp = {5'd0, held_bytes_r[0][3:0], held_bytes_r[1][5:0], in_byte[5:0]};
      default: cp = {held_bytes_r[0][2:0], held_bytes_r[1][5:0], held_bytes_r[2][5:0],
                     in_byte[5:0]};
    endcase
    cp_ok = 1'b1;
    if (seq_len_r == 3'd3 && (cp < jse_pkg::CP_MIN3 ||
        (cp >= jse_pkg::SURR_LO && cp <= jse_pkg::SURR_HI))) cp_ok = 1'b0;
    if (seq_len_r == 3'd4 && (cp < jse_pkg::CP_MIN4 || cp > jse_pkg::CP_MAX)) cp_ok = 1'b0;
  end

  always_comb begin
    cmd            = '0;
    held_count_nxt = held_count_r;
    seq_len_nxt    = seq_len_r;
    open_nxt       = open_r;
    wr_en          = 1'b0;
    wr_idx         = 2'd0;
    cmd.open       = (in_has_byte || in_end_of_string) && !open_r;
    if (in_has_byte || in_end_of_string) open_nxt = 1'b1;
    if (in_has_byte) begin
      if (held_count_r != 2'd0 && cont) begin
        if ({1'b0, held_count_r} + 3'd1 >= seq_len_r) begin
          if (cp_ok) begin
            cmd.body[0] = held_bytes_r[0];
            cmd.body[1] = held_bytes_r[1];
            cmd.body[2] = held_bytes_r[2];
            cmd.body[{1'b0, held_count_r}] = in_byte;
            cmd.body_len = {1'b0, held_count_r} + 3'd1;
          end else begin
            cmd.rep1 = {1'b0, held_count_r} + 3'd1;
          end
          held_count_nxt = 2'd0;
          seq_len_nxt    = 3'd0;
        end else begin
          wr_en          = 1'b1;
          wr_idx         = held_count_r;
          held_count_nxt = held_count_r + 2'd1;
        end
      end else begin
        cmd.rep1       = {1'b0, held_count_r};
        held_count_nxt = 2'd0;
        seq_len_nxt    = 3'd0;
        if (in_byte == jse_pkg::QUOTE || in_byte == jse_pkg::BSLASH) begin
          cmd.body[0]  = jse_pkg::BSLASH;
          cmd.body[1]  = in_byte;
          cmd.body_len = 3'd2;
        end else if (in_byte == jse_pkg::LF) begin
          cmd.body[0]  = jse_pkg::BSLASH;
          cmd.body[1]  = jse_pkg::CHR_N;
          cmd.body_len = 3'd2;
        end else if (in_byte == jse_pkg::TAB) begin
          cmd.body[0]  = jse_pkg::BSLASH;
          cmd.body[1]  = jse_pkg::CHR_T;
          cmd.body_len = 3'd2;
        end else if (in_byte < jse_pkg::CTRL_LIMIT) begin
          cmd.body[0]  = jse_pkg::BSLASH;
          cmd.body[1]  = jse_pkg::CHR_U;
          cmd.body[2]  = jse_pkg::CHR_0;
          cmd.body[3]  = jse_pkg::CHR_0;
          cmd.body[4]  = jse_pkg::hex_digit(in_byte[7:4]);
          cmd.body[5]  = jse_pkg::hex_digit(in_byte[3:0]);
          cmd.body_len = 3'd6;
        end else if (in_byte < jse_pkg::ASCII_LIMIT) begin
          cmd.body[0]  = in_byte;
          cmd.body_len = 3'd1;
        end else if (in_byte >= jse_pkg::LEAD2_LO && in_byte <= jse_pkg::LEAD2_HI) begin
          wr_en = 1'b1; held_count_nxt = 2'd1; seq_len_nxt = 3'd2;
        end else if (in_byte >= jse_pkg::LEAD3_LO && in_byte <= jse_pkg::LEAD3_HI) begin
          wr_en = 1'b1; held_count_nxt = 2'd1; seq_len_nxt = 3'd3;
        end else if (in_byte >= jse_pkg::LEAD4_LO && in_byte <= jse_pkg::LEAD4_HI) begin
          wr_en = 1'b1; held_count_nxt = 2'd1; seq_len_nxt = 3'd4;
        end else begin
          cmd.rep1 = {1'b0, held_count_r} + 3'd1;
        end
      end
    end
    if (in_end_of_string) begin
      cmd.rep2       = held_count_nxt;
      cmd.close      = 1'b1;
      held_count_nxt = 2'd0;
      seq_len_nxt    = 3'd0;
      open_nxt       = 1'b0;
    end
    cmd_valid = accept && (cmd.open || cmd.rep1 != 3'd0 || cmd.body_len != 3'd0 ||
                           cmd.rep2 != 2'd0 || cmd.close);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= 2'd0;
      seq_len_r    <= 3'd0;
      open_r       <= 1'b0;
    end else if (accept) begin
      held_count_r <= held_count_nxt;
      seq_len_r    <= seq_len_nxt;
      open_r       <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) held_bytes_r[wr_idx] <= in_byte;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/jse_queue.sv
// Small register queue between front and back.
// Generic width and depth; no package dependency.
`default_nettype none
module jse_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr, do_rd;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= bump(wr_ptr_r);
      if (do_rd) rd_ptr_r <= bump(rd_ptr_r);
      if (do_wr && !do_rd)      count_r <= count_r + CW'(1);
      else if (do_rd && !do_wr) count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wdata;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/jse_back.sv
// Back end: expands command words into registered output bytes, one per cycle while popped.
// Depends on jse_pkg.
`default_nettype none
module jse_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire jse_pkg::jse_cmd_t q_rdata,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   empty,
  input  wire logic              pop,
  output logic [7:0]             out_byte,
  output logic                   out_last
);

  jse_pkg::jse_cmd_t cur_r, cur_nxt;
  logic [2:0] k_r, k_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r, byte_nxt;
  logic       out_last_r, last_nxt;
  logic       active, adv, out_take;

  assign active   = cur_r.open || cur_r.rep1 != 3'd0 || cur_r.body_len != 3'd0 ||
                    cur_r.rep2 != 2'd0 || cur_r.close;
  assign out_take = pop && out_valid_r;
  assign adv      = active && (!out_valid_r || out_take);

  always_comb begin
    cur_nxt  = cur_r;
    k_nxt    = k_r;
    byte_nxt = 8'h00;
    if (cur_r.open) begin
      byte_nxt     = jse_pkg::QUOTE;
      cur_nxt.open = 1'b0;
    end else if (cur_r.rep1 != 3'd0) begin
      byte_nxt = jse_pkg::rep_char(k_r);
      if (k_r == jse_pkg::REP_LEN - 3'd1) begin
        k_nxt        = 3'd0;
        cur_nxt.rep1 = cur_r.rep1 - 3'd1;
      end else begin
        k_nxt = k_r + 3'd1;
      end
    end else if (cur_r.body_len != 3'd0) begin
      byte_nxt         = cur_r.body[0];
      cur_nxt.body     = {8'h00, cur_r.body[5:1]};
      cur_nxt.body_len = cur_r.body_len - 3'd1;
    end else if (cur_r.rep2 != 2'd0) begin
      byte_nxt = jse_pkg::rep_char(k_r);
      if (k_r == jse_pkg::REP_LEN - 3'd1) begin
        k_nxt        = 3'd0;
        cur_nxt.rep2 = cur_r.rep2 - 2'd1;
      end else begin
        k_nxt = k_r + 3'd1;
      end
    end else if (cur_r.close) begin
      byte_nxt      = jse_pkg::QUOTE;
      cur_nxt.close = 1'b0;
    end
    last_nxt = !cur_nxt.open && cur_nxt.rep1 == 3'd0 && cur_nxt.body_len == 3'd0 &&
               cur_nxt.rep2 == 2'd0 && !cur_nxt.close;
    q_pop    = !q_empty && (!active || (adv && last_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      k_r         <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop)    cur_r <= q_rdata;
      else if (adv) cur_r <= cur_nxt;
      if (adv)      k_r   <= k_nxt;
      if (adv)           out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= byte_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign empty    = !out_valid_r;
  assign out_byte = out_byte_r;
  assign out_last = out_last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/json_string_escaper_utf8.sv
// Top level of the JSON string escaper with UTF-8 validation.
// Throughput: one input word per cycle while the queue is not full; the back end emits
// one output byte per cycle while the output is popped, and a word expands to at most 25 bytes.
// Reset (rst_n low, synchronous): queue and output register empty, no string open.
// Depends on jse_pkg, jse_front, jse_queue, jse_back.
`default_nettype none
module json_string_escaper_utf8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_has_byte,
  input  wire logic       in_end_of_string,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  localparam int CMD_W = $bits(jse_pkg::jse_cmd_t);

  jse_pkg::jse_cmd_t cmd, q_rdata;
  logic              cmd_valid, q_empty, q_pop, accept;

  assign accept = push && !full;

  jse_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .in_byte          (in_byte),
    .in_has_byte      (in_has_byte),
    .in_end_of_string (in_end_of_string),
    .cmd              (cmd),
    .cmd_valid        (cmd_valid)
  );

  jse_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cmd_valid),
    .wdata (cmd),
    .full  (full),
    .rd_en (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  jse_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_rdata  (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule
`default_nettype wire
